[rtl/core/rcfd_pkg.sv]
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types and constants of the radio-control frame decoder: protocol and
// status codes, frame geometry and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  localparam int BUFFER_BYTES_DEF = 32;

  localparam int POS_W  = 6;   // byte position counter
  localparam int BYTE_W = 8;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 4;   // channel index
  localparam int VAL_W  = 16;  // channel value
  localparam int ACC_W  = 24;  // bit accumulator for channel unpacking
  localparam int BITS_W = 5;   // bits held in the accumulator

  localparam logic [MODE_W-1:0] MODE_IBUS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SBUS = 2'd2;

  // Frame geometry
  localparam logic [POS_W-1:0]  IBUS_LAST_POS  = 6'd31;
  localparam logic [POS_W-1:0]  SBUS_LAST_POS  = 6'd24;
  localparam int                IBUS_SUM_BYTES = 30;
  localparam int                IBUS_CHK_LO    = 30;
  localparam int                IBUS_CHK_HI    = 31;
  localparam int                SBUS_FLAG_BYTE = 23;
  localparam int                SBUS_FOOT_BYTE = 24;
  localparam int                IBUS_CH_START  = 2;
  localparam int                SBUS_CH_START  = 1;
  localparam logic [BITS_W-1:0] IBUS_CH_BITS   = 5'd16;
  localparam logic [BITS_W-1:0] SBUS_CH_BITS   = 5'd11;
  localparam logic [IDX_W-1:0]  IBUS_CH_LAST   = 4'd13;
  localparam logic [IDX_W-1:0]  SBUS_CH_LAST   = 4'd15;

  localparam logic [BYTE_W-1:0] IBUS_HDR0   = 8'h20;
  localparam logic [BYTE_W-1:0] IBUS_HDR1   = 8'h40;
  localparam logic [15:0]       IBUS_CHK_FS = 16'hFFFF;
  localparam logic [BYTE_W-1:0] SBUS_HDR    = 8'h0F;
  localparam logic [BYTE_W-1:0] SBUS_FOOT   = 8'h00;
  localparam int                SBUS_LOST_BIT = 5;
  localparam int                SBUS_FS_BIT   = 4;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_IBUS_HDR = 3'd1,
    STATUS_IBUS_CHK = 3'd2,
    STATUS_SBUS_HDR = 3'd3,
    STATUS_SBUS_FTR = 3'd4,
    STATUS_SIG_LOST = 3'd5,
    STATUS_FAILSAFE = 3'd6,
    STATUS_NO_PROTO = 3'd7
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // input byte transfer
    logic rd_check;    // buffer read during the check sweep
    logic rd_chan;     // buffer read during channel unpacking
    logic err_latch;   // capture the frame check result
    logic chan_start;  // prepare channel unpacking
    logic acc_load;    // append read byte to the accumulator
    logic emit_err;    // load an error result
    logic emit_ch;     // load a channel result
  } rcfd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_end;
    logic proto_off;
    logic addr_last;
    logic chk_err;
    logic have_word;
    logic chan_last;
    logic out_free;
  } rcfd_sts_t;

endpackage

[rtl/core/rc_receiver_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder_core
// Top level of the I.Bus / S.Bus radio-control frame decoder.
// ----------------------------------------------------------------------------
// Bytes are taken one per transfer and stored in a frame buffer with one write
// port and one read port. A byte that does not end a frame leaves the core
// ready for the next byte. In no-protocol mode every byte yields one error
// result, loaded as soon as the result register is free. The last byte of a
// frame starts a check sweep that reads the buffer one byte per cycle, then
// either one error result or the channel results: each payload byte is read
// through the buffer read port, appended to the accumulator and tested, and
// each channel is loaded as soon as the result register is free. No byte is
// taken until the last result of a frame has been loaded into the result
// register.
// ----------------------------------------------------------------------------
module rc_receiver_frame_decoder_core
  import rcfd_pkg::*;
#(
  parameter int BufferBytes = BUFFER_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MODE_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic               channel_valid_o,
  output logic [IDX_W-1:0]   channel_index_o,
  output logic [VAL_W-1:0]   channel_value_o,
  output logic               last_o
);

  rcfd_cmd_t cmd;
  rcfd_sts_t sts;

  rcfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rcfd_datapath #(
    .BufferBytes (BufferBytes)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rx_byte_i       (rx_byte_i),
    .frame_start_i   (frame_start_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .channel_valid_o (channel_valid_o),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .last_o          (last_o)
  );

endmodule

[rtl/core/rcfd_ctrl.sv]
// ----------------------------------------------------------------------------
// rcfd_ctrl
// Sequencer of the frame decoder: byte intake, frame check sweep, channel
// unpacking and result hand-off.
// ----------------------------------------------------------------------------
module rcfd_ctrl
  import rcfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rcfd_sts_t sts_i,
  output rcfd_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_DRAIN = 4'd2;
  localparam logic [3:0] ST_EVAL  = 4'd3;
  localparam logic [3:0] ST_ERR   = 4'd4;
  localparam logic [3:0] ST_RD    = 4'd5;
  localparam logic [3:0] ST_LD    = 4'd6;
  localparam logic [3:0] ST_TEST  = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.proto_off) begin
            state_d = ST_ERR;
          end else if (sts_i.frame_end) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        cmd_o.rd_check = 1'b1;
        if (sts_i.addr_last) begin
          state_d = ST_DRAIN;
        end
      end
      // The last byte of the sweep is folded into the check flags here.
      ST_DRAIN: state_d = ST_EVAL;
      ST_EVAL: begin
        cmd_o.err_latch = 1'b1;
        if (sts_i.chk_err) begin
          state_d = ST_ERR;
        end else begin
          cmd_o.chan_start = 1'b1;
          state_d          = ST_RD;
        end
      end
      ST_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd_o.rd_chan = 1'b1;
        state_d       = ST_LD;
      end
      ST_LD: begin
        cmd_o.acc_load = 1'b1;
        state_d        = ST_TEST;
      end
      ST_TEST: state_d = sts_i.have_word ? ST_EMIT : ST_RD;
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ch = 1'b1;
          state_d       = sts_i.chan_last ? ST_IDLE : ST_TEST;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/rcfd_datapath.sv]
// ----------------------------------------------------------------------------
// rcfd_datapath
// Frame buffer, byte position, protocol register, frame checks, channel
// unpacking accumulator and the result register.
// ----------------------------------------------------------------------------
module rcfd_datapath
  import rcfd_pkg::*;
#(
  parameter int BufferBytes = BUFFER_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MODE_W-1:0]  cfg_wdata_i,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  input  logic               frame_start_i,
  input  rcfd_cmd_t          cmd_i,
  output rcfd_sts_t          sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic               channel_valid_o,
  output logic [IDX_W-1:0]   channel_index_o,
  output logic [VAL_W-1:0]   channel_value_o,
  output logic               last_o
);

  localparam int AW = $clog2(BufferBytes);

  // ---- configuration and byte position ----
  logic [MODE_W-1:0] mode_q;
  logic [POS_W-1:0]  pos_q;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_inc;
  logic              is_ibus, is_sbus;
  logic              frame_end;

  assign is_ibus   = (mode_q == MODE_IBUS);
  assign is_sbus   = (mode_q == MODE_SBUS);
  assign pos       = frame_start_i ? '0 : pos_q;
  assign pos_inc   = pos + POS_W'(1);
  // A position past the frame length (after a mode change) also ends a frame.
  assign frame_end = (is_ibus && (pos >= IBUS_LAST_POS)) ||
                     (is_sbus && (pos >= SBUS_LAST_POS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      pos_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        pos_q <= frame_end ? '0 : pos_inc;
      end
    end
  end

  // ---- frame buffer ----
  logic [BYTE_W-1:0] mem [BufferBytes];
  logic              mem_we;
  logic [AW-1:0]     rd_addr_q;
  logic [BYTE_W-1:0] rd_data_q;

  assign mem_we = cmd_i.accept && ({1'b0, pos} < (POS_W+1)'(BufferBytes));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[pos[AW-1:0]] <= rx_byte_i;
    end
    rd_data_q <= mem[rd_addr_q];
  end

  // ---- read address and check sweep ----
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic [AW-1:0] last_addr;

  assign last_addr = is_ibus ? AW'(IBUS_LAST_POS) : AW'(SBUS_LAST_POS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_check;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_addr_q <= '0;
    end else if (cmd_i.chan_start) begin
      rd_addr_q <= is_ibus ? AW'(IBUS_CH_START) : AW'(SBUS_CH_START);
    end else if (cmd_i.rd_check || cmd_i.rd_chan) begin
      rd_addr_q <= rd_addr_q + AW'(1);
    end
    if (cmd_i.rd_check) begin
      rd_idx_q <= rd_addr_q;
    end
  end

  // ---- frame checks ----
  logic        b0_ok_q, b1_ok_q, foot_ok_q;
  logic [1:0]  flags_q;  // signal lost, failsafe
  logic [15:0] sum_q;
  logic [15:0] chk_q;
  status_e     chk_code;
  status_e     err_code_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sum_q <= '0;
    end else if (rd_vld_q) begin
      if (rd_idx_q == AW'(0)) begin
        b0_ok_q <= is_ibus ? (rd_data_q == IBUS_HDR0) : (rd_data_q == SBUS_HDR);
      end
      if (rd_idx_q == AW'(1)) begin
        b1_ok_q <= (rd_data_q == IBUS_HDR1);
      end
      if (rd_idx_q < AW'(IBUS_SUM_BYTES)) begin
        sum_q <= sum_q + {8'h00, rd_data_q};
      end
      if (rd_idx_q == AW'(IBUS_CHK_LO)) begin
        chk_q[7:0] <= rd_data_q;
      end
      if (rd_idx_q == AW'(IBUS_CHK_HI)) begin
        chk_q[15:8] <= rd_data_q;
      end
      if (rd_idx_q == AW'(SBUS_FLAG_BYTE)) begin
        flags_q <= {rd_data_q[SBUS_LOST_BIT], rd_data_q[SBUS_FS_BIT]};
      end
      if (rd_idx_q == AW'(SBUS_FOOT_BYTE)) begin
        foot_ok_q <= (rd_data_q == SBUS_FOOT);
      end
    end
  end

  always_comb begin
    chk_code = STATUS_OK;
    if (is_ibus) begin
      priority if (!(b0_ok_q && b1_ok_q)) begin
        chk_code = STATUS_IBUS_HDR;
      end else if ((IBUS_CHK_FS - sum_q) != chk_q) begin
        chk_code = STATUS_IBUS_CHK;
      end else begin
        chk_code = STATUS_OK;
      end
    end else begin
      priority if (!b0_ok_q) begin
        chk_code = STATUS_SBUS_HDR;
      end else if (!foot_ok_q) begin
        chk_code = STATUS_SBUS_FTR;
      end else if (flags_q[1]) begin
        chk_code = STATUS_SIG_LOST;
      end else if (flags_q[0]) begin
        chk_code = STATUS_FAILSAFE;
      end else begin
        chk_code = STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      err_code_q <= STATUS_NO_PROTO;
    end else if (cmd_i.err_latch) begin
      err_code_q <= chk_code;
    end
  end

  // ---- channel unpacking: bytes enter LSB first, words leave from the bottom ----
  logic [ACC_W-1:0]  acc_q;
  logic [BITS_W-1:0] bits_q;
  logic [IDX_W-1:0]  ch_idx_q;
  logic [BITS_W-1:0] word_bits;
  logic [VAL_W-1:0]  word;

  assign word_bits = is_ibus ? IBUS_CH_BITS : SBUS_CH_BITS;
  assign word      = is_ibus ? acc_q[VAL_W-1:0] : {5'b0, acc_q[10:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.chan_start) begin
      acc_q    <= '0;
      bits_q   <= '0;
      ch_idx_q <= '0;
    end else if (cmd_i.acc_load) begin
      acc_q  <= acc_q | ({16'h0000, rd_data_q} << bits_q);
      bits_q <= bits_q + BITS_W'(BYTE_W);
    end else if (cmd_i.emit_ch) begin
      acc_q    <= acc_q >> word_bits;
      bits_q   <= bits_q - word_bits;
      ch_idx_q <= ch_idx_q + IDX_W'(1);
    end
  end

  // ---- result register ----
  logic             out_valid_q;
  logic [2:0]       status_q;
  logic             cvalid_q;
  logic [IDX_W-1:0] cidx_q;
  logic [VAL_W-1:0] cval_q;
  logic             last_q;
  logic             out_free;
  logic             chan_last;

  assign out_free  = !out_valid_q || out_ready_i;
  assign chan_last = (ch_idx_q == (is_ibus ? IBUS_CH_LAST : SBUS_CH_LAST));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_err || cmd_i.emit_ch) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_err) begin
      status_q <= err_code_q;
      cvalid_q <= 1'b0;
      cidx_q   <= '0;
      cval_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.emit_ch) begin
      status_q <= STATUS_OK;
      cvalid_q <= 1'b1;
      cidx_q   <= ch_idx_q;
      cval_q   <= word;
      last_q   <= chan_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign channel_valid_o = cvalid_q;
  assign channel_index_o = cidx_q;
  assign channel_value_o = cval_q;
  assign last_o          = last_q;

  assign sts_o.frame_end = frame_end;
  assign sts_o.proto_off = !(is_ibus || is_sbus);
  assign sts_o.addr_last = (rd_addr_q == last_addr);
  assign sts_o.chk_err   = (chk_code != STATUS_OK);
  assign sts_o.have_word = (bits_q >= word_bits);
  assign sts_o.chan_last = chan_last;
  assign sts_o.out_free  = out_free;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the radio-control frame decoder core.
// ----------------------------------------------------------------------------
// A table of directed frames comes first. It covers no-protocol bytes after
// reset, good and broken I.Bus and S.Bus frames, a restart in mid-frame and
// mode changes while a frame is half received. Random frames and noise follow
// under several patterns of sender idling and receiver stalls. Every result
// transfer is checked field by field against a typed status or a local frame
// decoder with its own copy of the buffer, byte position and protocol mode.
// ----------------------------------------------------------------------------
module tb;
  import rcfd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;

  localparam int RAND_ITEMS     = 280;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int IBUS_FRAME_LEN = int'(IBUS_LAST_POS) + 1;
  localparam int SBUS_FRAME_LEN = int'(SBUS_LAST_POS) + 1;
  localparam int RESTART_BYTES  = 10;

  typedef enum logic [3:0] {
    K_RAW,
    K_CONT,
    K_IBUS_GOOD,
    K_IBUS_HDR0,
    K_IBUS_HDR1,
    K_IBUS_CHK,
    K_IBUS_RESTART,
    K_SBUS_GOOD,
    K_SBUS_HDR,
    K_SBUS_FTR,
    K_SBUS_LOST,
    K_SBUS_FS,
    K_SBUS_BOTH
  } frame_kind_e;

  typedef struct packed {
    status_e          status;
    logic             chan_valid;
    logic [IDX_W-1:0] chan_index;
    logic [VAL_W-1:0] chan_value;
    logic             last;
  } chan_res_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    frame_kind_e       kind;
    logic [7:0]        count;
    logic [7:0]        fill;
    logic              has_exp;
    status_e           exp_status;
  } dir_row_t;

  localparam int DIR_ROWS = 20;

  // Rows with has_exp set carry the error status typed in; the rest are
  // checked against the local decoder.
  dir_row_t dir_tab [DIR_ROWS] = '{
    // The first row writes every buffer entry, so no frame reads stale bytes.
    '{MODE_NONE, K_RAW,          8'd32,  8'h00, 1'b1, STATUS_NO_PROTO},
    '{MODE_NONE, K_RAW,          8'd1,   8'hFF, 1'b1, STATUS_NO_PROTO},
    '{MODE_IBUS, K_IBUS_GOOD,    8'd0,   8'hFF, 1'b0, STATUS_OK},
    '{MODE_IBUS, K_IBUS_GOOD,    8'd0,   8'h00, 1'b0, STATUS_OK},
    '{MODE_IBUS, K_IBUS_HDR0,    8'd0,   8'h11, 1'b1, STATUS_IBUS_HDR},
    '{MODE_IBUS, K_IBUS_HDR1,    8'd0,   8'h22, 1'b1, STATUS_IBUS_HDR},
    '{MODE_IBUS, K_IBUS_CHK,     8'd0,   8'h33, 1'b1, STATUS_IBUS_CHK},
    '{MODE_IBUS, K_IBUS_RESTART, 8'd0,   8'hC3, 1'b0, STATUS_OK},
    '{MODE_SBUS, K_SBUS_GOOD,    8'd0,   8'hFF, 1'b0, STATUS_OK},
    '{MODE_SBUS, K_SBUS_GOOD,    8'd0,   8'h00, 1'b0, STATUS_OK},
    '{MODE_SBUS, K_SBUS_GOOD,    8'd0,   8'hA5, 1'b0, STATUS_OK},
    '{MODE_SBUS, K_SBUS_HDR,     8'd0,   8'h44, 1'b1, STATUS_SBUS_HDR},
    '{MODE_SBUS, K_SBUS_FTR,     8'd0,   8'h55, 1'b1, STATUS_SBUS_FTR},
    '{MODE_SBUS, K_SBUS_LOST,    8'd0,   8'h66, 1'b1, STATUS_SIG_LOST},
    '{MODE_SBUS, K_SBUS_FS,      8'd0,   8'h77, 1'b1, STATUS_FAILSAFE},
    // Signal lost takes precedence over failsafe.
    '{MODE_SBUS, K_SBUS_BOTH,    8'd0,   8'h88, 1'b1, STATUS_SIG_LOST},
    // Switching to S.Bus at position 27 ends the frame on the next byte.
    '{MODE_IBUS, K_RAW,          8'd27,  8'h55, 1'b0, STATUS_OK},
    '{MODE_SBUS, K_CONT,         8'd1,   8'h55, 1'b1, STATUS_SBUS_HDR},
    // The position wraps past 63 and stops at 36, beyond the I.Bus end.
    '{MODE_NONE, K_RAW,          8'd100, 8'hA5, 1'b1, STATUS_NO_PROTO},
    '{MODE_IBUS, K_CONT,         8'd1,   8'hA5, 1'b1, STATUS_IBUS_HDR}
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [MODE_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_start;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        res_status;
  logic              res_chan_valid;
  logic [IDX_W-1:0]  res_chan_index;
  logic [VAL_W-1:0]  res_chan_value;
  logic              res_last;

  // Local decoder state
  logic [BYTE_W-1:0] frame_mem [BUFFER_BYTES_DEF];
  logic [POS_W-1:0]  pred_pos;
  logic [MODE_W-1:0] pred_mode;
  chan_res_t         pred_out [$];
  chan_res_t         exp_results [$];

  logic [BYTE_W-1:0] frame_bytes [$];
  logic              frame_starts [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int sent_cnt      = 0;
  int err_cnt       = 0;
  int stuck_cycles  = 0;

  rc_receiver_frame_decoder_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .rx_byte_i       (rx_byte),
    .frame_start_i   (frame_start),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (res_status),
    .channel_valid_o (res_chan_valid),
    .channel_index_o (res_chan_index),
    .channel_value_o (res_chan_value),
    .last_o          (res_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic chan_res_t err_res(input status_e st);
    chan_res_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // Works out the results that one accepted byte causes.
  function automatic void predict_byte(input logic [BYTE_W-1:0] b, input logic start);
    int          pos;
    int          flen;
    int          i;
    int          bitpos;
    int          bi;
    logic [15:0] sum;
    logic [15:0] chk;
    logic [23:0] w;
    chan_res_t   r;
    pred_out.delete();
    pos = start ? 0 : int'(pred_pos);
    if (pos < BUFFER_BYTES_DEF) frame_mem[pos] = b;
    if (pred_mode == MODE_IBUS) begin
      flen = IBUS_FRAME_LEN;
    end else if (pred_mode == MODE_SBUS) begin
      flen = SBUS_FRAME_LEN;
    end else begin
      pred_pos = POS_W'(pos + 1);
      pred_out.push_back(err_res(STATUS_NO_PROTO));
      return;
    end
    if (pos + 1 < flen) begin
      pred_pos = POS_W'(pos + 1);
      return;
    end
    pred_pos = '0;
    if (pred_mode == MODE_IBUS) begin
      sum = '0;
      for (i = 0; i < IBUS_SUM_BYTES; i++) sum = sum + 16'(frame_mem[i]);
      chk = {frame_mem[IBUS_CHK_HI], frame_mem[IBUS_CHK_LO]};
      if (frame_mem[0] != IBUS_HDR0 || frame_mem[1] != IBUS_HDR1) begin
        pred_out.push_back(err_res(STATUS_IBUS_HDR));
      end else if (16'(IBUS_CHK_FS - sum) != chk) begin
        pred_out.push_back(err_res(STATUS_IBUS_CHK));
      end else begin
        for (i = 0; i <= int'(IBUS_CH_LAST); i++) begin
          r            = '0;
          r.status     = STATUS_OK;
          r.chan_valid = 1'b1;
          r.chan_index = IDX_W'(i);
          r.chan_value = {frame_mem[2 * i + 3], frame_mem[2 * i + 2]};
          r.last       = (i == int'(IBUS_CH_LAST));
          pred_out.push_back(r);
        end
      end
    end else begin
      if (frame_mem[0] != SBUS_HDR) begin
        pred_out.push_back(err_res(STATUS_SBUS_HDR));
      end else if (frame_mem[SBUS_FOOT_BYTE] != SBUS_FOOT) begin
        pred_out.push_back(err_res(STATUS_SBUS_FTR));
      end else if (frame_mem[SBUS_FLAG_BYTE][SBUS_LOST_BIT]) begin
        pred_out.push_back(err_res(STATUS_SIG_LOST));
      end else if (frame_mem[SBUS_FLAG_BYTE][SBUS_FS_BIT]) begin
        pred_out.push_back(err_res(STATUS_FAILSAFE));
      end else begin
        // Channels are packed 11 bits each, LSB first, from byte 1.
        for (i = 0; i <= int'(SBUS_CH_LAST); i++) begin
          bitpos       = 11 * i;
          bi           = SBUS_CH_START + bitpos / 8;
          w            = {frame_mem[bi + 2], frame_mem[bi + 1], frame_mem[bi]};
          w            = w >> (bitpos % 8);
          r            = '0;
          r.status     = STATUS_OK;
          r.chan_valid = 1'b1;
          r.chan_index = IDX_W'(i);
          r.chan_value = {5'd0, w[10:0]};
          r.last       = (i == int'(SBUS_CH_LAST));
          pred_out.push_back(r);
        end
      end
    end
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte(input logic [BYTE_W-1:0] fill, input bit rnd);
    return rnd ? 8'($urandom) : fill;
  endfunction

  // Fills frame_bytes and frame_starts with one frame of the given kind.
  function automatic void build_frame(input frame_kind_e kind, input int count,
                                      input logic [BYTE_W-1:0] fill, input bit rnd);
    logic [BYTE_W-1:0] flip;
    logic [15:0]       sum;
    int                i;
    int                n;
    frame_bytes.delete();
    frame_starts.delete();
    n    = 0;
    flip = rnd ? 8'($urandom_range(1, 255)) : 8'h80;
    if (kind >= K_IBUS_GOOD && kind <= K_IBUS_RESTART) begin
      if (kind == K_IBUS_RESTART)
        for (i = 0; i < RESTART_BYTES; i++) frame_bytes.push_back(pick_byte(fill, rnd));
      n = frame_bytes.size();
      frame_bytes.push_back(IBUS_HDR0);
      frame_bytes.push_back(IBUS_HDR1);
      for (i = IBUS_CH_START; i < IBUS_SUM_BYTES; i++) frame_bytes.push_back(pick_byte(fill, rnd));
      sum = '0;
      for (i = 0; i < IBUS_SUM_BYTES; i++) sum = sum + 16'(frame_bytes[n + i]);
      sum = IBUS_CHK_FS - sum;
      frame_bytes.push_back(sum[7:0]);
      frame_bytes.push_back(sum[15:8]);
      if (kind == K_IBUS_HDR0) frame_bytes[n] = frame_bytes[n] ^ flip;
      if (kind == K_IBUS_HDR1) frame_bytes[n + 1] = frame_bytes[n + 1] ^ flip;
      if (kind == K_IBUS_CHK) begin
        i = n + (rnd ? int'($urandom_range(IBUS_CHK_LO, IBUS_CHK_HI)) : IBUS_CHK_LO);
        frame_bytes[i] = frame_bytes[i] ^ flip;
      end
    end else if (kind >= K_SBUS_GOOD) begin
      frame_bytes.push_back(SBUS_HDR);
      for (i = SBUS_CH_START; i < SBUS_FLAG_BYTE; i++) frame_bytes.push_back(pick_byte(fill, rnd));
      frame_bytes.push_back(pick_byte(fill, rnd) & ~8'h30);
      frame_bytes.push_back(SBUS_FOOT);
      if (kind == K_SBUS_HDR) frame_bytes[0] = frame_bytes[0] ^ flip;
      if (kind == K_SBUS_FTR) frame_bytes[SBUS_FOOT_BYTE] = flip;
      if (kind == K_SBUS_LOST || kind == K_SBUS_BOTH)
        frame_bytes[SBUS_FLAG_BYTE] = frame_bytes[SBUS_FLAG_BYTE] | (8'h01 << SBUS_LOST_BIT);
      if (kind == K_SBUS_FS || kind == K_SBUS_BOTH)
        frame_bytes[SBUS_FLAG_BYTE] = frame_bytes[SBUS_FLAG_BYTE] | (8'h01 << SBUS_FS_BIT);
    end else begin
      for (i = 0; i < count; i++) frame_bytes.push_back(pick_byte(fill, rnd));
    end
    for (i = 0; i < frame_bytes.size(); i++) frame_starts.push_back(i == 0 && kind != K_CONT);
    if (kind == K_IBUS_RESTART) frame_starts[n] = 1'b1;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start,
                           input bit typed, input status_e typed_st);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // The byte transfer happened at this edge.
    predict_byte(b, start);
    foreach (pred_out[k]) exp_results.push_back(typed ? err_res(typed_st) : pred_out[k]);
    sent_cnt++;
  endtask

  task automatic send_frame(input bit typed, input status_e typed_st);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], frame_starts[i], typed, typed_st);
  endtask

  // The mode is only changed once every result is out and the core has settled.
  task automatic set_mode(input logic [MODE_W-1:0] m);
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    pred_mode = m;
  endtask

  function automatic void check_field(input string name, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    chan_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exp_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d index %0d value %0h",
                 $time, res_status, res_chan_index, res_chan_value);
        err_cnt++;
      end else begin
        want = exp_results.pop_front();
        check_field("status", 16'(want.status), 16'(res_status));
        check_field("channel_valid", 16'(want.chan_valid), 16'(res_chan_valid));
        check_field("channel_index", 16'(want.chan_index), 16'(res_chan_index));
        check_field("channel_value", want.chan_value, res_chan_value);
        check_field("last", 16'(want.last), 16'(res_last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin : result_sink
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin : stimulus
    int                r;
    logic [MODE_W-1:0] m;
    frame_kind_e       kind;
    dir_row_t          row;
    in_valid    = 1'b0;
    rx_byte     = '0;
    frame_start = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = MODE_NONE;
    rst_n       = 1'b0;
    pred_pos    = '0;
    pred_mode   = MODE_NONE;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.mode != pred_mode) set_mode(row.mode);
      build_frame(row.kind, int'(row.count), row.fill, 1'b0);
      send_frame(row.has_exp, row.exp_status);
    end

    sent_cnt = 0;
    while (sent_cnt < RAND_ITEMS) begin
      case (sent_cnt * 4 / RAND_ITEMS)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 57; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // Well-formed frame, now and then broken or misaligned.
        m = $urandom_range(0, 1) ? MODE_IBUS : MODE_SBUS;
        if (m != pred_mode) set_mode(m);
        r = $urandom_range(0, 99);
        if (m == MODE_IBUS)
          kind = (r < 70) ? K_IBUS_GOOD : frame_kind_e'(int'(K_IBUS_HDR0) + r % 4);
        else
          kind = (r < 70) ? K_SBUS_GOOD : frame_kind_e'(int'(K_SBUS_HDR) + r % 5);
        build_frame(kind, 0, 8'h00, 1'b1);
        if ($urandom_range(0, 9) == 0) frame_starts[0] = 1'b0;
        if ($urandom_range(0, 29) == 0)
          frame_starts[$urandom_range(1, frame_starts.size() - 1)] = 1'b1;
        send_frame(1'b0, STATUS_OK);
      end else if (r < 80) begin
        if (pred_mode != MODE_NONE) set_mode(MODE_NONE);
        build_frame(K_RAW, $urandom_range(1, 8), 8'h00, 1'b1);
        frame_starts[0] = $urandom_range(0, 1);
        send_frame(1'b0, STATUS_OK);
      end else if (r < 90) begin
        // Part of a frame in one protocol, finished in the other.
        m = $urandom_range(0, 1) ? MODE_IBUS : MODE_SBUS;
        if (m != pred_mode) set_mode(m);
        build_frame(K_RAW, $urandom_range(1, 30), 8'h00, 1'b1);
        send_frame(1'b0, STATUS_OK);
        set_mode((m == MODE_IBUS) ? MODE_SBUS : MODE_IBUS);
        while (pred_pos != '0) send_byte(8'($urandom), 1'b0, 1'b0, STATUS_OK);
      end else begin
        build_frame(K_CONT, $urandom_range(1, 5), 8'h00, 1'b1);
        foreach (frame_starts[i]) frame_starts[i] = ($urandom_range(0, 3) == 0);
        send_frame(1'b0, STATUS_OK);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
